// File: hw/rtl/sm83alu_pkg.sv
// ----------------------------------------------------------------------------
// sm83alu_pkg
// Types and codes shared by the 8-bit console processor ALU and its top level.
// ----------------------------------------------------------------------------
package sm83alu_pkg;

    // Operation codes carried in req_type
    typedef enum logic [4:0] {
        ALU_ADD   = 5'd0,
        ALU_ADC   = 5'd1,
        ALU_SUB   = 5'd2,
        ALU_SBC   = 5'd3,
        ALU_AND   = 5'd4,
        ALU_XOR   = 5'd5,
        ALU_OR    = 5'd6,
        ALU_CP    = 5'd7,
        ALU_INC8  = 5'd8,
        ALU_DEC8  = 5'd9,
        ALU_RLC   = 5'd10,
        ALU_RRC   = 5'd11,
        ALU_RL    = 5'd12,
        ALU_RR    = 5'd13,
        ALU_SLA   = 5'd14,
        ALU_SRA   = 5'd15,
        ALU_SRL   = 5'd16,
        ALU_SWAP  = 5'd17,
        ALU_BIT   = 5'd18,
        ALU_SET   = 5'd19,
        ALU_RES   = 5'd20,
        ALU_CPL   = 5'd21,
        ALU_CCF   = 5'd22,
        ALU_SCF   = 5'd23,
        ALU_ADD16 = 5'd24,
        ALU_INC16 = 5'd25,
        ALU_DEC16 = 5'd26,
        ALU_ADDSP = 5'd27,
        ALU_RLCA  = 5'd28,
        ALU_RRCA  = 5'd29,
        ALU_RLA   = 5'd30,
        ALU_RRA   = 5'd31
    } t_alu_op;

    // Flag bit positions in flags_in / flags_out
    localparam int unsigned FLAG_Z = 3;
    localparam int unsigned FLAG_N = 2;
    localparam int unsigned FLAG_H = 1;
    localparam int unsigned FLAG_C = 0;

    // One operation request
    typedef struct packed {
        logic [4:0]  req_type;
        logic [15:0] operand_a;
        logic [15:0] operand_b;
        logic [3:0]  flags_in;
    } t_alu_req;

    // One operation result
    typedef struct packed {
        logic [15:0] result;
        logic [3:0]  flags_out;
    } t_alu_rsp;

endpackage

// File: hw/rtl/sm83alu_calc.sv
// ----------------------------------------------------------------------------
// sm83alu_calc
// Single-pass datapath: computes the result value and new Z/N/H/C flags
// for one request.
// ----------------------------------------------------------------------------
module sm83alu_calc (
    input  sm83alu_pkg::t_alu_req i_req,
    output sm83alu_pkg::t_alu_rsp o_rsp
);

    function automatic logic f_zero(input logic [7:0] v);
        f_zero = (v == 8'd0);
    endfunction

    sm83alu_pkg::t_alu_op w_op;
    logic [15:0] w_a16;
    logic [15:0] w_b16;
    logic [7:0]  w_a;
    logic [7:0]  w_b;
    logic [3:0]  w_fin;
    logic        w_c;
    logic        w_add_cin;
    logic        w_sub_cin;
    logic [8:0]  w_add9;
    logic [4:0]  w_addh5;
    logic [8:0]  w_sub9;
    logic [4:0]  w_subh5;
    logic [8:0]  w_sp9;
    logic [4:0]  w_sph5;
    logic [16:0] w_add17;
    logic [12:0] w_add13;
    logic [15:0] w_sext_b;
    logic [7:0]  w_bitm;

    logic [7:0]  c_r8;
    logic [15:0] c_result;
    logic [3:0]  c_flags;

    // Split the request into operand bytes and flags
    assign w_op      = sm83alu_pkg::t_alu_op'(i_req.req_type);
    assign w_a16     = i_req.operand_a;
    assign w_b16     = i_req.operand_b;
    assign w_a       = w_a16[7:0];
    assign w_b       = w_b16[7:0];
    assign w_fin     = i_req.flags_in;
    assign w_c       = w_fin[sm83alu_pkg::FLAG_C];
    assign w_add_cin = (w_op == sm83alu_pkg::ALU_ADC) & w_c;
    assign w_sub_cin = (w_op == sm83alu_pkg::ALU_SBC) & w_c;

    // Shared adders; borrow shows up as the top bit of the differences
    assign w_add9   = {1'b0, w_a} + {1'b0, w_b} + {8'd0, w_add_cin};
    assign w_addh5  = {1'b0, w_a[3:0]} + {1'b0, w_b[3:0]} + {4'd0, w_add_cin};
    assign w_sub9   = {1'b0, w_a} - {1'b0, w_b} - {8'd0, w_sub_cin};
    assign w_subh5  = {1'b0, w_a[3:0]} - {1'b0, w_b[3:0]} - {4'd0, w_sub_cin};
    assign w_sp9    = {1'b0, w_a} + {1'b0, w_b};
    assign w_sph5   = {1'b0, w_a[3:0]} + {1'b0, w_b[3:0]};
    assign w_add17  = {1'b0, w_a16} + {1'b0, w_b16};
    assign w_add13  = {1'b0, w_a16[11:0]} + {1'b0, w_b16[11:0]};
    assign w_sext_b = {{8{w_b[7]}}, w_b};
    assign w_bitm   = 8'd1 << w_b16[2:0];

    // Select the result and flags for the operation
    always_comb begin
        c_r8     = 8'd0;
        c_result = 16'd0;
        c_flags  = w_fin;
        unique case (w_op)
            sm83alu_pkg::ALU_ADD, sm83alu_pkg::ALU_ADC: begin
                c_r8     = w_add9[7:0];
                c_result = {8'd0, c_r8};
                c_flags  = {f_zero(c_r8), 1'b0, w_addh5[4], w_add9[8]};
            end
            sm83alu_pkg::ALU_SUB, sm83alu_pkg::ALU_SBC, sm83alu_pkg::ALU_CP: begin
                c_r8     = w_sub9[7:0];
                c_result = (w_op == sm83alu_pkg::ALU_CP) ? w_a16 : {8'd0, c_r8};
                c_flags  = {f_zero(c_r8), 1'b1, w_subh5[4], w_sub9[8]};
            end
            sm83alu_pkg::ALU_AND: begin
                c_r8     = w_a & w_b;
                c_result = {8'd0, c_r8};
                c_flags  = {f_zero(c_r8), 1'b0, 1'b1, 1'b0};
            end
            sm83alu_pkg::ALU_XOR: begin
                c_r8     = w_a ^ w_b;
                c_result = {8'd0, c_r8};
                c_flags  = {f_zero(c_r8), 3'b000};
            end
            sm83alu_pkg::ALU_OR: begin
                c_r8     = w_a | w_b;
                c_result = {8'd0, c_r8};
                c_flags  = {f_zero(c_r8), 3'b000};
            end
            sm83alu_pkg::ALU_INC8: begin
                c_r8     = w_a + 8'd1;
                c_result = {8'd0, c_r8};
                c_flags  = {f_zero(c_r8), 1'b0, (w_a[3:0] == 4'hF), w_c};
            end
            sm83alu_pkg::ALU_DEC8: begin
                c_r8     = w_a - 8'd1;
                c_result = {8'd0, c_r8};
                c_flags  = {f_zero(c_r8), 1'b1, (w_a[3:0] == 4'h0), w_c};
            end
            sm83alu_pkg::ALU_RLC, sm83alu_pkg::ALU_RLCA: begin
                c_r8     = {w_a[6:0], w_a[7]};
                c_result = {8'd0, c_r8};
                c_flags  = {(w_op == sm83alu_pkg::ALU_RLC) & f_zero(c_r8), 2'b00, w_a[7]};
            end
            sm83alu_pkg::ALU_RRC, sm83alu_pkg::ALU_RRCA: begin
                c_r8     = {w_a[0], w_a[7:1]};
                c_result = {8'd0, c_r8};
                c_flags  = {(w_op == sm83alu_pkg::ALU_RRC) & f_zero(c_r8), 2'b00, w_a[0]};
            end
            sm83alu_pkg::ALU_RL, sm83alu_pkg::ALU_RLA: begin
                c_r8     = {w_a[6:0], w_c};
                c_result = {8'd0, c_r8};
                c_flags  = {(w_op == sm83alu_pkg::ALU_RL) & f_zero(c_r8), 2'b00, w_a[7]};
            end
            sm83alu_pkg::ALU_RR, sm83alu_pkg::ALU_RRA: begin
                c_r8     = {w_c, w_a[7:1]};
                c_result = {8'd0, c_r8};
                c_flags  = {(w_op == sm83alu_pkg::ALU_RR) & f_zero(c_r8), 2'b00, w_a[0]};
            end
            sm83alu_pkg::ALU_SLA: begin
                c_r8     = {w_a[6:0], 1'b0};
                c_result = {8'd0, c_r8};
                c_flags  = {f_zero(c_r8), 2'b00, w_a[7]};
            end
            sm83alu_pkg::ALU_SRA: begin
                c_r8     = {w_a[7], w_a[7:1]};
                c_result = {8'd0, c_r8};
                c_flags  = {f_zero(c_r8), 2'b00, w_a[0]};
            end
            sm83alu_pkg::ALU_SRL: begin
                c_r8     = {1'b0, w_a[7:1]};
                c_result = {8'd0, c_r8};
                c_flags  = {f_zero(c_r8), 2'b00, w_a[0]};
            end
            sm83alu_pkg::ALU_SWAP: begin
                c_r8     = {w_a[3:0], w_a[7:4]};
                c_result = {8'd0, c_r8};
                c_flags  = {f_zero(c_r8), 3'b000};
            end
            sm83alu_pkg::ALU_BIT: begin
                c_result = w_a16;
                c_flags  = {f_zero(w_a & w_bitm), 1'b0, 1'b1, w_c};
            end
            sm83alu_pkg::ALU_SET: begin
                c_r8     = w_a | w_bitm;
                c_result = {8'd0, c_r8};
            end
            sm83alu_pkg::ALU_RES: begin
                c_r8     = w_a & ~w_bitm;
                c_result = {8'd0, c_r8};
            end
            sm83alu_pkg::ALU_CPL: begin
                c_r8     = ~w_a;
                c_result = {8'd0, c_r8};
                c_flags  = {w_fin[sm83alu_pkg::FLAG_Z], 1'b1, 1'b1, w_c};
            end
            sm83alu_pkg::ALU_CCF: begin
                c_result = w_a16;
                c_flags  = {w_fin[sm83alu_pkg::FLAG_Z], 2'b00, ~w_c};
            end
            sm83alu_pkg::ALU_SCF: begin
                c_result = w_a16;
                c_flags  = {w_fin[sm83alu_pkg::FLAG_Z], 2'b00, 1'b1};
            end
            sm83alu_pkg::ALU_ADD16: begin
                c_result = w_add17[15:0];
                c_flags  = {w_fin[sm83alu_pkg::FLAG_Z], 1'b0, w_add13[12], w_add17[16]};
            end
            sm83alu_pkg::ALU_INC16: begin
                c_result = w_a16 + 16'd1;
            end
            sm83alu_pkg::ALU_DEC16: begin
                c_result = w_a16 - 16'd1;
            end
            sm83alu_pkg::ALU_ADDSP: begin
                c_result = w_a16 + w_sext_b;
                c_flags  = {2'b00, w_sph5[4], w_sp9[8]};
            end
        endcase
    end

    assign o_rsp.result    = c_result;
    assign o_rsp.flags_out = c_flags;

endmodule

// File: hw/rtl/sm83_alu_with_flags_unit.sv
// ----------------------------------------------------------------------------
// sm83_alu_with_flags_unit
// 8-bit console processor ALU with Z/N/H/C flag generation, registered
// on both sides of a single combinational pass.
// ----------------------------------------------------------------------------
//  channel   | ports                      | transfer
//  ----------+----------------------------+----------------------------------
//  request   | start, busy, i_req         | edge with start high, busy low
//  result    | o_strobe, o_rsp            | edge ending the o_strobe cycle
//
//  One request is taken every cycle; busy is always low.
//  Each result passes through the input register, the datapath and then the
//  result register, in that order.
//  Reset (synchronous, active low) drops any request in flight.
//  The receiver cannot stall, so nothing here ever waits.
// ----------------------------------------------------------------------------
module sm83_alu_with_flags_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  sm83alu_pkg::t_alu_req i_req,
    output logic                  o_strobe,
    output sm83alu_pkg::t_alu_rsp o_rsp
);

    logic                  r_in_vld;
    sm83alu_pkg::t_alu_req r_in;
    logic                  r_out_vld;
    sm83alu_pkg::t_alu_rsp r_out;
    sm83alu_pkg::t_alu_rsp w_rsp;

    // Never hold off a request
    assign busy = 1'b0;

    // Capture the request on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= start & ~busy;
        end
        r_in <= i_req;
    end

    sm83alu_calc u_calc (
        .i_req (r_in),
        .o_rsp (w_rsp)
    );

    // Register the result and its strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_in_vld;
        end
        r_out <= w_rsp;
    end

    assign o_strobe = r_out_vld;
    assign o_rsp    = r_out;

`ifndef NO_ASSERTIONS
    // Every transfer yields a result strobe
    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_strobe)
        else $error("request transfer produced no result strobe");

    // No strobe without a matching earlier request
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !start |=> ##1 !o_strobe)
        else $error("result strobe without a request");

    // Compare passes operand_a through unchanged
    a_cp_passthru: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && i_req.req_type == sm83alu_pkg::ALU_CP) |=> ##1
        (o_rsp.result == $past(i_req.operand_a, 2)))
        else $error("compare did not pass operand_a through");

    // Sixteen-bit increment keeps all flags
    a_inc16_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && i_req.req_type == sm83alu_pkg::ALU_INC16) |=> ##1
        (o_rsp.flags_out == $past(i_req.flags_in, 2)))
        else $error("16-bit increment changed flags");

    // Logic operations always clear the carry flag
    a_logic_noc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && (i_req.req_type == sm83alu_pkg::ALU_AND ||
                   i_req.req_type == sm83alu_pkg::ALU_XOR ||
                   i_req.req_type == sm83alu_pkg::ALU_OR)) |=> ##1
        !o_rsp.flags_out[sm83alu_pkg::FLAG_C])
        else $error("logic operation set carry");
`endif

endmodule

// File: dv/sm83_alu_sb_pkg.sv
// ----------------------------------------------------------------------------
// sm83_alu_sb_pkg
// Expected-value calculation and result checking for the console processor
// ALU: every accepted request queues the flags and value it must produce,
// and each result strobe is compared in order against that queue.
// ----------------------------------------------------------------------------
package sm83_alu_sb_pkg;

    import sm83alu_pkg::*;

    // Compute the value and the Z/N/H/C flags that one request must produce
    function automatic t_alu_rsp sm83_alu_eval(input t_alu_req q);
        logic [15:0] a16;
        logic [15:0] b16;
        logic [15:0] r16;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  r8;
        logic [7:0]  bitm;
        logic [8:0]  s9;
        logic [4:0]  s5;
        logic [16:0] s17;
        logic [12:0] s13;
        logic [3:0]  fin;
        logic [3:0]  f;
        logic        c;
        logic        cin;
        t_alu_rsp    rsp;

        a16  = q.operand_a;
        b16  = q.operand_b;
        a    = a16[7:0];
        b    = b16[7:0];
        fin  = q.flags_in;
        c    = fin[FLAG_C];
        bitm = 8'h01 << b16[2:0];
        f    = fin;
        r16  = '0;

        case (q.req_type)
            ALU_ADD, ALU_ADC: begin
                cin = (q.req_type == ALU_ADC) ? c : 1'b0;
                s9  = {1'b0, a} + {1'b0, b} + {8'h00, cin};
                s5  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, cin};
                r16 = {8'h00, s9[7:0]};
                f   = {s9[7:0] == 8'h00, 1'b0, s5[4], s9[8]};
            end
            ALU_SUB, ALU_SBC, ALU_CP: begin
                // bit 8 / bit 4 of the difference is the borrow
                cin = (q.req_type == ALU_SBC) ? c : 1'b0;
                s9  = {1'b0, a} - {1'b0, b} - {8'h00, cin};
                s5  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'h0, cin};
                r16 = (q.req_type == ALU_CP) ? a16 : {8'h00, s9[7:0]};
                f   = {s9[7:0] == 8'h00, 1'b1, s5[4], s9[8]};
            end
            ALU_AND: begin
                r8  = a & b;
                r16 = {8'h00, r8};
                f   = {r8 == 8'h00, 1'b0, 1'b1, 1'b0};
            end
            ALU_XOR, ALU_OR: begin
                r8  = (q.req_type == ALU_XOR) ? (a ^ b) : (a | b);
                r16 = {8'h00, r8};
                f   = {r8 == 8'h00, 3'b000};
            end
            ALU_INC8: begin
                r8  = a + 8'h01;
                r16 = {8'h00, r8};
                f   = {r8 == 8'h00, 1'b0, a[3:0] == 4'hF, c};
            end
            ALU_DEC8: begin
                r8  = a - 8'h01;
                r16 = {8'h00, r8};
                f   = {r8 == 8'h00, 1'b1, a[3:0] == 4'h0, c};
            end
            ALU_RLC, ALU_RLCA: begin
                r8  = {a[6:0], a[7]};
                r16 = {8'h00, r8};
                f   = {(q.req_type == ALU_RLC) && (r8 == 8'h00), 2'b00, a[7]};
            end
            ALU_RRC, ALU_RRCA: begin
                r8  = {a[0], a[7:1]};
                r16 = {8'h00, r8};
                f   = {(q.req_type == ALU_RRC) && (r8 == 8'h00), 2'b00, a[0]};
            end
            ALU_RL, ALU_RLA: begin
                r8  = {a[6:0], c};
                r16 = {8'h00, r8};
                f   = {(q.req_type == ALU_RL) && (r8 == 8'h00), 2'b00, a[7]};
            end
            ALU_RR, ALU_RRA: begin
                r8  = {c, a[7:1]};
                r16 = {8'h00, r8};
                f   = {(q.req_type == ALU_RR) && (r8 == 8'h00), 2'b00, a[0]};
            end
            ALU_SLA: begin
                r8  = {a[6:0], 1'b0};
                r16 = {8'h00, r8};
                f   = {r8 == 8'h00, 2'b00, a[7]};
            end
            ALU_SRA, ALU_SRL: begin
                r8  = {(q.req_type == ALU_SRA) ? a[7] : 1'b0, a[7:1]};
                r16 = {8'h00, r8};
                f   = {r8 == 8'h00, 2'b00, a[0]};
            end
            ALU_SWAP: begin
                r8  = {a[3:0], a[7:4]};
                r16 = {8'h00, r8};
                f   = {r8 == 8'h00, 3'b000};
            end
            ALU_BIT: begin
                r16 = a16;
                f   = {(a & bitm) == 8'h00, 1'b0, 1'b1, c};
            end
            ALU_SET: begin
                r16 = {8'h00, a | bitm};
            end
            ALU_RES: begin
                r16 = {8'h00, a & ~bitm};
            end
            ALU_CPL: begin
                r16 = {8'h00, ~a};
                f[FLAG_N] = 1'b1;
                f[FLAG_H] = 1'b1;
            end
            ALU_CCF: begin
                r16 = a16;
                f   = {fin[FLAG_Z], 2'b00, ~c};
            end
            ALU_SCF: begin
                r16 = a16;
                f   = {fin[FLAG_Z], 2'b00, 1'b1};
            end
            ALU_ADD16: begin
                s17 = {1'b0, a16} + {1'b0, b16};
                s13 = {1'b0, a16[11:0]} + {1'b0, b16[11:0]};
                r16 = s17[15:0];
                f   = {fin[FLAG_Z], 1'b0, s13[12], s17[16]};
            end
            ALU_INC16: begin
                r16 = a16 + 16'h0001;
            end
            ALU_DEC16: begin
                r16 = a16 - 16'h0001;
            end
            ALU_ADDSP: begin
                // flags come from the unsigned low-byte add
                s9  = {1'b0, a} + {1'b0, b};
                s5  = {1'b0, a[3:0]} + {1'b0, b[3:0]};
                r16 = a16 + {{8{b[7]}}, b};
                f   = {2'b00, s5[4], s9[8]};
            end
            default: begin
                r16 = 'x;
                f   = 'x;
            end
        endcase

        rsp.result    = r16;
        rsp.flags_out = f;
        return rsp;
    endfunction

    // In-order checker of result transfers against queued expectations
    class alu_scoreboard;
        t_alu_rsp    awaited_rsp[$];
        int unsigned mismatch_cnt;

        function new();
            mismatch_cnt = 0;
        endfunction

        // Queue what an accepted request must return
        function void note_req(input t_alu_req q);
            awaited_rsp.push_back(sm83_alu_eval(q));
        endfunction

        // Compare one result transfer with the oldest expectation
        function void check_rsp(input t_alu_rsp got, input time stamp);
            t_alu_rsp want;
            if (awaited_rsp.size() == 0) begin
                mismatch_cnt++;
                $display("%0t: unexpected result: expected none, actual result %h flags %b",
                         stamp, got.result, got.flags_out);
                return;
            end
            want = awaited_rsp.pop_front();
            if (got.result !== want.result) begin
                mismatch_cnt++;
                $display("%0t: result mismatch: expected %h, actual %h",
                         stamp, want.result, got.result);
            end
            if (got.flags_out !== want.flags_out) begin
                mismatch_cnt++;
                $display("%0t: flags mismatch: expected %b, actual %b",
                         stamp, want.flags_out, got.flags_out);
            end
        endfunction

        function int unsigned pending();
            return awaited_rsp.size();
        endfunction
    endclass

endpackage

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the console processor ALU: directed corner requests for
// every operation, then random requests under several sender idle patterns,
// each result checked in order against a computed expectation.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import sm83alu_pkg::*;
    import sm83_alu_sb_pkg::*;

    localparam int unsigned RAND_PER_PHASE = 152;
    localparam int unsigned DRAIN_LIMIT    = 200;
    localparam int unsigned TAIL_CYCLES    = 4;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     start   = 1'b0;
    logic     busy;
    t_alu_req i_req   = '0;
    logic     o_strobe;
    t_alu_rsp o_rsp;

    alu_scoreboard sb = new();

    sm83_alu_with_flags_unit u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_strobe (o_strobe),
        .o_rsp    (o_rsp)
    );

    // Free-running clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("[sm83_alu_with_flags_unit] ERROR");
        $finish;
    end

    // Note request transfers, then check result transfers
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                sb.note_req(i_req);
            end
            if (o_strobe) begin
                sb.check_rsp(o_rsp, $time);
            end
        end
    end

    function automatic t_alu_req make_req(input t_alu_op op, input logic [15:0] a,
                                          input logic [15:0] b, input logic [3:0] f);
        t_alu_req q;
        q.req_type  = op;
        q.operand_a = a;
        q.operand_b = b;
        q.flags_in  = f;
        return q;
    endfunction

    // Bias operands toward byte and nibble boundaries
    function automatic logic [15:0] pick_operand();
        logic [15:0] w;
        w = 16'($urandom);
        case ($urandom_range(7))
            0: w = 16'h0000;
            1: w = 16'hFFFF;
            2: w[7:0] = $urandom_range(1) ? 8'h80 : 8'h7F;
            3: w[3:0] = $urandom_range(1) ? 4'hF : 4'h0;
            4: w[7:0] = $urandom_range(1) ? 8'hFF : 8'h00;
            default: ;
        endcase
        return w;
    endfunction

    // Hold start low for random gaps, then present one request until transfer
    task automatic send_req(input t_alu_req q, input int unsigned idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= q;
        do begin
            @(posedge i_clk);
        end while (busy);
    endtask

    // Drop start and wait until every expected result has come back
    task automatic wait_drained();
        int unsigned guard;
        guard = 0;
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
    endtask

    // Every operation once on corner operands, then named corner cases
    task automatic run_directed();
        logic [4:0] op;
        for (int i = 0; i < 32; i++) begin
            op = 5'(i);
            send_req(make_req(t_alu_op'(op), op[0] ? 16'hFFFF : 16'h0000,
                              op[1] ? 16'hFFFF : 16'h0001, op[3:0]), 0);
        end
        send_req(make_req(ALU_ADD,   16'h00FF, 16'h0001, 4'b0000), 0);
        send_req(make_req(ALU_SUB,   16'h0000, 16'h0001, 4'b0000), 0);
        send_req(make_req(ALU_ADC,   16'h000F, 16'h00F0, 4'b0001), 0);
        send_req(make_req(ALU_SBC,   16'h0010, 16'h000F, 4'b0001), 0);
        send_req(make_req(ALU_CP,    16'hAB12, 16'hCD12, 4'b0000), 0);
        send_req(make_req(ALU_BIT,   16'h0004, 16'h00FA, 4'b1000), 0);
        send_req(make_req(ALU_SET,   16'hFF00, 16'hFF0F, 4'b1111), 0);
        send_req(make_req(ALU_RES,   16'hFFFF, 16'h0108, 4'b0000), 0);
        send_req(make_req(ALU_ADD16, 16'h8FFF, 16'hF001, 4'b1000), 0);
        send_req(make_req(ALU_ADDSP, 16'hFFF0, 16'h0010, 4'b1111), 0);
        send_req(make_req(ALU_RLCA,  16'h0080, 16'h0000, 4'b1000), 0);
        send_req(make_req(ALU_SWAP,  16'hFF00, 16'h0000, 4'b0000), 0);
    endtask

    // Random requests at one sender idle rate
    task automatic run_random(input int unsigned idle_pct);
        for (int i = 0; i < RAND_PER_PHASE; i++) begin
            send_req(make_req(t_alu_op'($urandom_range(31)), pick_operand(),
                              pick_operand(), 4'($urandom_range(15))), idle_pct);
        end
    endtask

    // Main sequence
    initial begin
        int unsigned idle_pct[4];
        idle_pct = '{0, 67, 0, 28};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        wait_drained();

        foreach (idle_pct[p]) begin
            run_random(idle_pct[p]);
            // hold the sender off until the pipe is empty between phases
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (sb.pending() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, sb.pending());
        end
        if (sb.mismatch_cnt == 0 && sb.pending() == 0) begin
            $display("[sm83_alu_with_flags_unit] OK");
        end else begin
            $display("[sm83_alu_with_flags_unit] ERROR");
        end
        $finish;
    end

endmodule
